// ----- rtl/base64_stream_encoder_core_macros.svh -----
// Assertion helpers shared by the encoder modules.
`ifndef BASE64_STREAM_ENCODER_CORE_MACROS_SVH
`define BASE64_STREAM_ENCODER_CORE_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define B64SE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off while reset is high.
`define B64SE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/b64se_pkg.sv -----
`default_nettype none

package b64se_pkg;

   localparam logic [7:0] PAD_CHAR = 8'h3D;
   localparam logic [5:0] SIX_MASK = 6'h3F;

   localparam logic [1:0] HELD_NONE = 2'd0;
   localparam logic [1:0] HELD_ONE  = 2'd1;
   localparam logic [1:0] HELD_TWO  = 2'd2;

   localparam logic [1:0] PAD_NONE = 2'd0;
   localparam logic [1:0] PAD_ONE  = 2'd1;
   localparam logic [1:0] PAD_TWO  = 2'd2;

   localparam logic [1:0] SLOT_FIRST  = 2'd0;
   localparam logic [1:0] SLOT_SECOND = 2'd1;
   localparam logic [1:0] SLOT_THIRD  = 2'd2;
   localparam logic [1:0] SLOT_LAST   = 2'd3;

   typedef struct packed {
      logic [23:0] word;
      logic [1:0]  pad_count;
      logic        last;
   } group_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [7:0] sextet_char(input logic [5:0] sextet);
      logic [7:0] s;
      s = {2'b00, sextet & SIX_MASK};
      if (s < 8'd26) begin
         return s + 8'd65;
      end else if (s < 8'd52) begin
         return s + 8'd71;
      end else if (s < 8'd62) begin
         return s - 8'd4;
      end else if (s == 8'd62) begin
         return 8'h2B;
      end else begin
         return 8'h2F;
      end
   endfunction

endpackage

`default_nettype wire

// ----- rtl/b64se_front.sv -----
`default_nettype none
`include "base64_stream_encoder_core_macros.svh"

module b64se_front (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_tvalid,
   output logic                         req_tready,
   input  wire  [7:0]                   req_tdata,
   input  wire                          req_tlast,
   input  b64se_pkg::queue_status_type  queue_status,
   output logic                         push,
   output b64se_pkg::group_type         push_group
);
   import b64se_pkg::*;

   logic [7:0] first_pending_ff, first_pending_in;
   logic [7:0] second_pending_ff, second_pending_in;
   logic [1:0] pending_count_ff, pending_count_in;
   logic       accept;

   assign req_tready = !queue_status.full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      first_pending_in  = first_pending_ff;
      second_pending_in = second_pending_ff;
      pending_count_in  = pending_count_ff;
      push              = 1'b0;
      push_group.word      = {first_pending_ff, second_pending_ff, req_tdata};
      push_group.pad_count = PAD_NONE;
      push_group.last      = req_tlast;
      unique case (pending_count_ff)
         HELD_NONE: begin
            push_group.word      = {req_tdata, 16'h0000};
            push_group.pad_count = PAD_TWO;
            if (accept) begin
               if (req_tlast) begin
                  push = 1'b1;
               end else begin
                  first_pending_in = req_tdata;
                  pending_count_in = HELD_ONE;
               end
            end
         end
         HELD_ONE: begin
            push_group.word      = {first_pending_ff, req_tdata, 8'h00};
            push_group.pad_count = PAD_ONE;
            if (accept) begin
               if (req_tlast) begin
                  push             = 1'b1;
                  pending_count_in = HELD_NONE;
               end else begin
                  second_pending_in = req_tdata;
                  pending_count_in  = HELD_TWO;
               end
            end
         end
         default: begin
            if (accept) begin
               push             = 1'b1;
               pending_count_in = HELD_NONE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_count_ff  <= HELD_NONE;
         first_pending_ff  <= 8'h00;
         second_pending_ff <= 8'h00;
      end else begin
         pending_count_ff  <= pending_count_in;
         first_pending_ff  <= first_pending_in;
         second_pending_ff <= second_pending_in;
      end
   end

   `B64SE_ASSERT_NOW(a_count_range, clock, reset, 1'b1, pending_count_ff <= HELD_TWO, "pending count out of range")
   `B64SE_ASSERT_NEXT(a_push_clears, clock, reset, push, pending_count_ff == HELD_NONE, "held bytes kept after group")

endmodule

`default_nettype wire

// ----- rtl/b64se_queue.sv -----
`default_nettype none
`include "base64_stream_encoder_core_macros.svh"

module b64se_queue #(
   parameter int DEPTH = 2
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          push,
   input  b64se_pkg::group_type         push_group,
   input  wire                          pop,
   output b64se_pkg::group_type         head_group,
   output b64se_pkg::queue_status_type  queue_status
);
   import b64se_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   group_type       slots_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   assign queue_status.full  = (count_ff == CW'(DEPTH));
   assign queue_status.empty = (count_ff == '0);
   assign head_group         = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_group;
      end
   end

   `B64SE_ASSERT_NOW(a_no_overflow, clock, reset, push, !queue_status.full, "group pushed into full queue")
   `B64SE_ASSERT_NOW(a_no_underflow, clock, reset, pop, !queue_status.empty, "group popped from empty queue")

endmodule

`default_nettype wire

// ----- rtl/b64se_back.sv -----
`default_nettype none
`include "base64_stream_encoder_core_macros.svh"

module b64se_back (
   input  wire                          clock,
   input  wire                          reset,
   input  b64se_pkg::group_type         head_group,
   input  b64se_pkg::queue_status_type  queue_status,
   output logic                         pop,
   output logic                         rsp_tvalid,
   input  wire                          rsp_tready,
   output logic [7:0]                   rsp_tdata,
   output logic                         rsp_tlast
);
   import b64se_pkg::*;

   logic [1:0] slot_ff, slot_in;
   logic       rsp_tvalid_ff, rsp_tvalid_in;
   logic [7:0] rsp_tdata_ff, rsp_tdata_in;
   logic       rsp_tlast_ff, rsp_tlast_in;
   logic       load;
   logic [7:0] next_char;

   assign load = !queue_status.empty && (!rsp_tvalid_ff || rsp_tready);
   assign pop  = load && (slot_ff == SLOT_LAST);

   always_comb begin
      unique case (slot_ff)
         SLOT_FIRST:  next_char = sextet_char(head_group.word[23:18]);
         SLOT_SECOND: next_char = sextet_char(head_group.word[17:12]);
         SLOT_THIRD:  next_char = (head_group.pad_count == PAD_TWO) ? PAD_CHAR
                                : sextet_char(head_group.word[11:6]);
         default: next_char = (head_group.pad_count != PAD_NONE) ? PAD_CHAR
                            : sextet_char(head_group.word[5:0]);
      endcase
   end

   always_comb begin
      slot_in       = slot_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tlast_in  = rsp_tlast_ff;
      if (load) begin
         slot_in       = slot_ff + 1'b1;
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = next_char;
         rsp_tlast_in  = (slot_ff == SLOT_LAST) && head_group.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff       <= SLOT_FIRST;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         slot_ff       <= slot_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tlast_ff <= rsp_tlast_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   `B64SE_ASSERT_NOW(a_group_held, clock, reset, slot_ff != SLOT_FIRST, !queue_status.empty, "group left queue mid-emission")

endmodule

`default_nettype wire

// ----- rtl/base64_stream_encoder_core.sv -----
// Streaming base64 encoder (standard alphabet, '=' padding).
// req_*: one raw message byte per word; tlast marks the final byte.
// rsp_*: one ASCII character per word; tlast marks the last character.
// Bytes are gathered into groups of three in the front end; a complete group,
// or a partial one closed by tlast, goes into a small queue of QUEUE_DEPTH
// groups. The back end turns each group into four characters, one per cycle
// while rsp_tready stays high, into an output register.
// A closing byte's group is written into the queue, and its first character
// is then loaded from the queue into the output register.
// Throughput: up to one byte per cycle in while the queue is not full, one
// character per cycle out while rsp_tready is high; the output side sets the
// long-run rate at four characters per three-byte group.
// req_tready drops only while the queue is full.
// Reset clears held bytes, empties the queue and drops the output register's valid flag.
// A stalled rsp_tready holds the current character; the queue then fills and
// the input side backs up.
`default_nettype none

module base64_stream_encoder_core #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_tvalid,
   output logic       req_tready,
   input  wire  [7:0] req_tdata,   // [7:0] data_byte
   input  wire        req_tlast,
   output logic       rsp_tvalid,
   input  wire        rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_char
   output logic       rsp_tlast
);
   import b64se_pkg::*;

   logic             push;
   logic             pop;
   group_type        push_group;
   group_type        head_group;
   queue_status_type queue_status;

   b64se_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tlast    (req_tlast),
      .queue_status (queue_status),
      .push         (push),
      .push_group   (push_group)
   );

   b64se_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .push_group   (push_group),
      .pop          (pop),
      .head_group   (head_group),
      .queue_status (queue_status)
   );

   b64se_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_group   (head_group),
      .queue_status (queue_status),
      .pop          (pop),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tlast    (rsp_tlast)
   );

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
   import b64se_pkg::*;

   typedef struct packed {
      logic [7:0] ch;
      logic       eot;
   } enc_char_type;

   class encoded_text_scoreboard;
      string     alphabet =
         "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
      logic [7:0] held_a;
      logic [7:0] held_b;
      logic [1:0] held_n;
      enc_char_type expected_chars[$];
      int         errors;

      function new();
         held_a = '0;
         held_b = '0;
         held_n = HELD_NONE;
         errors = 0;
      endfunction

      // Emit n alphabet characters from the group, pad the rest with '='.
      function void emit_group(logic [23:0] grp, int n, logic fin);
         enc_char_type c;
         logic [5:0]   sx;
         for (int k = 0; k < 4; k++) begin
            sx = 6'((grp >> (18 - 6 * k)) & 24'h3F);
            c.ch  = (k < n) ? 8'(alphabet[sx]) : PAD_CHAR;
            c.eot = (k == 3) && fin;
            expected_chars = {expected_chars, c};
         end
         held_n = HELD_NONE;
      endfunction

      function void note_byte(logic [7:0] b, logic fin);
         unique case (held_n)
            HELD_NONE: begin
               if (!fin) begin
                  held_a = b;
                  held_n = HELD_ONE;
               end else begin
                  emit_group({b, 16'h0000}, 2, 1'b1);
               end
            end
            HELD_ONE: begin
               if (!fin) begin
                  held_b = b;
                  held_n = HELD_TWO;
               end else begin
                  emit_group({held_a, b, 8'h00}, 3, 1'b1);
               end
            end
            default: begin
               emit_group({held_a, held_b, b}, 4, fin);
            end
         endcase
      endfunction

      function void check_char(logic [7:0] ch, logic eot);
         enc_char_type c;
         if (expected_chars.size() == 0) begin
            $error("unexpected character: out_char %h end_of_text %b", ch, eot);
            errors++;
         end else begin
            c = expected_chars.pop_front();
            if (c.ch !== ch) begin
               $error("out_char mismatch: expected %h, actual %h", c.ch, ch);
               errors++;
            end
            if (c.eot !== eot) begin
               $error("end_of_text mismatch: expected %b, actual %b", c.eot, eot);
               errors++;
            end
         end
      endfunction

      function int pending();
         return expected_chars.size();
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;
   logic       req_tlast = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic       rsp_tlast;

   logic send_idle = 1'b1;
   logic recv_idle = 1'b1;

   encoded_text_scoreboard sb = new();

   base64_stream_encoder_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // [7:0] data_byte
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),    // [7:0] out_char
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic send_byte(input logic [7:0] b, input logic fin);
      int gap;
      gap = send_idle ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= fin;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_byte(b, fin);
   endtask

   task automatic send_message(input int len);
      logic [7:0] b;
      for (int i = 0; i < len; i++) begin
         case ($urandom_range(0, 7))
            0:       b = 8'h00;
            1:       b = 8'hFF;
            default: b = 8'($urandom_range(0, 255));
         endcase
         send_byte(b, i == len - 1);
      end
   endtask

   // Receiver: hold ready low for a random count, then take one word.
   initial begin
      int gap;
      while (reset) @(posedge clock);
      forever begin
         gap = recv_idle ? $urandom_range(0, 8) : 0;
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_char(rsp_tdata, rsp_tlast);
      end
   end

   logic [7:0] seed_bytes [21] = '{
      8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF,
      8'h00, 8'h00, 8'h00, 8'h4D, 8'h61, 8'h6E, 8'h21,
      8'hFB, 8'hFF, 8'hBF, 8'hEF, 8'h7E};
   logic       seed_last  [21] = '{
      1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1,
      1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1,
      1'b0, 1'b0, 1'b0, 1'b0, 1'b1};

   initial begin
      int  sent;
      int  len;
      bit  paused;
      sent   = 0;
      paused = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < 21; i++) begin
         send_byte(seed_bytes[i], seed_last[i]);
      end
      while (sent < 250) begin
         send_idle = ($urandom_range(0, 3) != 0);
         recv_idle = ($urandom_range(0, 3) != 0);
         len = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
         send_message(len);
         sent += len;
         if (!paused && sent > 120) begin
            paused = 1;
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (sb.pending() != 0) @(posedge clock);
         end
      end
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $error("timeout with %0d characters outstanding", sb.pending());
      $display("FAILURE");
      $finish;
   end

endmodule
